// ----- rtl/core/lruc_pkg.sv -----
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared sizes, codes and types of the LRU cache with expiry.
// ----------------------------------------------------------------------------
`default_nettype none

package lruc_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;

    // Fixed widths of the request and response fields
    localparam int KEY_FIELD_W = 64;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 7;
    localparam int OCC_W       = 7;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int VST_W   = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam int STAMP_W = 64;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [VST_W-1:0]    value;
        logic [DATA_W-1:0]   expiry;
        logic                sgn;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Outcome of one walk over the entry memory
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] fslot;
        t_entry           fentry;
        logic             have_v;
        logic [IDX_W-1:0] vslot;
        logic             have_free;
        logic [IDX_W-1:0] free;
    } t_scan;

endpackage

`default_nettype wire

// ----- rtl/core/lruc_ram.sv -----
// ----------------------------------------------------------------------------
// lruc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/lruc_scan.sv -----
// ----------------------------------------------------------------------------
// lruc_scan
// Walks the entry read data: key match, least recent entry, first free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lruc_scan
    import lruc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clear,
    input  wire logic                i_chk_valid,
    input  wire logic [IDX_W-1:0]    i_chk_idx,
    input  wire logic                i_chk_used,
    input  wire t_entry              i_rdata,
    input  wire logic [KEY_BITS-1:0] i_key,
    output t_scan                    o_res
);

    t_scan              r_res, n_res;
    logic [STAMP_W-1:0] r_vstamp, n_vstamp;

    always_comb begin
        n_res    = r_res;
        n_vstamp = r_vstamp;
        if (i_clear) begin
            n_res.found     = 1'b0;
            n_res.have_v    = 1'b0;
            n_res.have_free = 1'b0;
        end else if (i_chk_valid) begin
            if (i_chk_used && (i_rdata.key == i_key)) begin
                n_res.found  = 1'b1;
                n_res.fslot  = i_chk_idx;
                n_res.fentry = i_rdata;
            end
            // oldest stamp is the least recent entry
            if (i_chk_used && (!r_res.have_v || (i_rdata.stamp < r_vstamp))) begin
                n_res.have_v = 1'b1;
                n_res.vslot  = i_chk_idx;
                n_vstamp     = i_rdata.stamp;
            end
            if (!i_chk_used && !r_res.have_free) begin
                n_res.have_free = 1'b1;
                n_res.free      = i_chk_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.found     <= 1'b0;
            r_res.have_v    <= 1'b0;
            r_res.have_free <= 1'b0;
        end else begin
            r_res.found     <= n_res.found;
            r_res.have_v    <= n_res.have_v;
            r_res.have_free <= n_res.have_free;
        end
        r_res.fslot  <= n_res.fslot;
        r_res.fentry <= n_res.fentry;
        r_res.vslot  <= n_res.vslot;
        r_res.free   <= n_res.free;
        r_vstamp     <= n_vstamp;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- rtl/core/lru_cache_with_expiry_unit.sv -----
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_unit
// Fully associative LRU cache with expiry times, one entry memory walked per
// request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time: the request side stalls until the walk over
//   the single read port of the entry memory, one slot a cycle, has finished and
//   the response has been loaded into the output register.
// Reset: synchronous, active low; empties the cache (valid bits and count
//   cleared at once, no clearing pass) and sets max_entries to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_with_expiry_unit
    import lruc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    // request channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_opcode,
    input  wire logic [KEY_FIELD_W-1:0] i_lookup_key,
    input  wire logic [DATA_W-1:0]      i_write_value,
    input  wire logic [DATA_W-1:0]      i_time_to_live,
    input  wire logic                   i_write_signed_ok,
    input  wire logic [DATA_W-1:0]      i_now_seconds,
    // response channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_hit,
    output logic      [DATA_W-1:0]      o_read_value,
    output logic                        o_read_signed_ok,
    output logic      [OCC_W-1:0]       o_occupancy,
    output logic                        o_evicted
);

    // Sequencer states: take a request, walk all slots, settle, decide, hand off
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LAST   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_chk_valid;
    logic [IDX_W-1:0]    r_chk_idx;

    logic [CFG_W-1:0]    r_max_entries;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STAMP_W-1:0]  r_clock, n_clock;

    // latched request
    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [VST_W-1:0]    r_wval;
    logic [DATA_W-1:0]   r_exp;
    logic                r_wsig;
    logic [DATA_W-1:0]   r_now;

    // response waiting for the output register
    logic                r_p_hit, n_p_hit;
    logic [VST_W-1:0]    r_p_val, n_p_val;
    logic                r_p_sig, n_p_sig;
    logic                r_p_evict, n_p_evict;

    // output register
    logic                r_out_valid;
    logic                r_o_hit;
    logic [DATA_W-1:0]   r_o_val;
    logic                r_o_sig;
    logic [OCC_W-1:0]    r_o_occ;
    logic                r_o_evict;

    logic                in_acc;
    logic                out_free;
    logic [DATA_W:0]     exp_sum;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;
    logic [ENTRY_W-1:0]  mem_rdata;
    t_scan               sr;

    logic [CMP_W-1:0]    cfg_ext;
    logic [CMP_W-1:0]    limit;
    logic                expired;
    logic                evict;
    logic                ins_ok;
    logic [IDX_W-1:0]    ins_slot;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exp_sum    = {1'b0, i_now_seconds} + {1'b0, i_time_to_live};

    // ------------------------------------------------------------------
    // Entry memory. Reads only happen during the walk and the single write
    // happens in S_DECIDE, so a read never overlaps a pending write: the
    // sequencer itself is the interlock.
    // ------------------------------------------------------------------
    lruc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // Read data of slot r_chk_idx arrives in the cycle after its address
    lruc_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (in_acc),
        .i_chk_valid (r_chk_valid),
        .i_chk_idx   (r_chk_idx),
        .i_chk_used  (r_used[r_chk_idx]),
        .i_rdata     (t_entry'(mem_rdata)),
        .i_key       (r_key),
        .o_res       (sr)
    );

    // Entry limit: zero acts as one, anything above the capacity as the capacity
    always_comb begin
        cfg_ext = CMP_W'(r_max_entries);
        if (cfg_ext == '0) begin
            limit = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(CAPACITY)) begin
            limit = CMP_W'(CAPACITY);
        end else begin
            limit = cfg_ext;
        end
    end

    assign expired = r_now > sr.fentry.expiry;
    // New key into a cache at or above the limit: drop the least recent first
    assign evict   = (r_op == OP_WRITE) && !sr.found && sr.have_v &&
                     (CMP_W'(r_count) >= limit);
    assign ins_ok  = sr.have_free || evict;
    // Lowest free slot, counting the one the eviction opens up
    assign ins_slot = (evict && !(sr.have_free && (sr.free < sr.vslot))) ?
                      sr.vslot : sr.free;

    // ------------------------------------------------------------------
    // Sequencer and read-modify-write of the chosen slot
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_used    = r_used;
        n_count   = r_count;
        n_clock   = r_clock;
        n_p_hit   = r_p_hit;
        n_p_val   = r_p_val;
        n_p_sig   = r_p_sig;
        n_p_evict = r_p_evict;
        mem_we    = 1'b0;
        mem_waddr = sr.fslot;
        mem_wdata.key    = r_key;
        mem_wdata.value  = r_wval;
        mem_wdata.expiry = r_exp;
        mem_wdata.sgn    = r_wsig;
        mem_wdata.stamp  = r_clock;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_LAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_p_hit   = 1'b0;
                n_p_val   = '0;
                n_p_sig   = 1'b0;
                n_p_evict = 1'b0;
                if (r_op == OP_LOOKUP) begin
                    if (sr.found) begin
                        if (expired) begin
                            n_used[sr.fslot] = 1'b0;
                            n_count          = r_count - CNT_W'(1);
                        end else begin
                            // touch: rewrite the entry with a fresh stamp
                            mem_we           = 1'b1;
                            mem_wdata.value  = sr.fentry.value;
                            mem_wdata.expiry = sr.fentry.expiry;
                            mem_wdata.sgn    = sr.fentry.sgn;
                            n_clock          = r_clock + STAMP_W'(1);
                            n_p_hit          = 1'b1;
                            n_p_val          = sr.fentry.value;
                            n_p_sig          = sr.fentry.sgn;
                        end
                    end
                end else if (sr.found) begin
                    // update in place, no expiry check
                    mem_we  = 1'b1;
                    n_clock = r_clock + STAMP_W'(1);
                end else begin
                    if (evict) begin
                        n_used[sr.vslot] = 1'b0;
                        n_p_evict        = 1'b1;
                    end
                    if (ins_ok) begin
                        mem_we           = 1'b1;
                        mem_waddr        = ins_slot;
                        n_used[ins_slot] = 1'b1;
                        n_clock          = r_clock + STAMP_W'(1);
                    end
                    n_count = r_count - CNT_W'(evict) + CNT_W'(ins_ok);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_chk_valid   <= 1'b0;
            r_max_entries <= MAX_ENTRIES_RST;
            r_used        <= '0;
            r_count       <= '0;
            r_clock       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= (r_state == S_SCAN);
            r_used      <= n_used;
            r_count     <= n_count;
            r_clock     <= n_clock;
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
            // load a finished response, or drop one the sink has taken
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_chk_idx <= r_idx;
        r_p_hit   <= n_p_hit;
        r_p_val   <= n_p_val;
        r_p_sig   <= n_p_sig;
        r_p_evict <= n_p_evict;
        if (in_acc) begin
            r_op   <= i_opcode;
            r_key  <= i_lookup_key[KEY_BITS-1:0];
            r_wval <= i_write_value[VST_W-1:0];
            r_exp  <= exp_sum[DATA_W] ? '1 : exp_sum[DATA_W-1:0];
            r_wsig <= i_write_signed_ok;
            r_now  <= i_now_seconds;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_o_hit   <= r_p_hit;
            r_o_val   <= DATA_W'(r_p_val);
            r_o_sig   <= r_p_sig;
            r_o_occ   <= OCC_W'(r_count);
            r_o_evict <= r_p_evict;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_o_hit;
    assign o_read_value     = r_o_val;
    assign o_read_signed_ok = r_o_sig;
    assign o_occupancy      = r_o_occ;
    assign o_evicted        = r_o_evict;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_used) == 32'(r_count)))
        else $error("entry count disagrees with valid bits");

    a_resp_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("response raised outside the hand-off state");

    a_no_evict_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DECIDE) && (r_op == OP_LOOKUP)) |=> !r_p_evict)
        else $error("lookup reported an eviction");

endmodule

`default_nettype wire

// ----- tb/lru_cache_with_expiry_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_unit_checker
// Watches the request and response channels of the cache. Keeps its own copy
// of the entries, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module lru_cache_with_expiry_unit_checker
    import lruc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_opcode,
    input  logic [KEY_FIELD_W-1:0] i_lookup_key,
    input  logic [DATA_W-1:0]      i_write_value,
    input  logic [DATA_W-1:0]      i_time_to_live,
    input  logic                   i_write_signed_ok,
    input  logic [DATA_W-1:0]      i_now_seconds,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_hit,
    input  logic [DATA_W-1:0]      i_read_value,
    input  logic                   i_read_signed_ok,
    input  logic [OCC_W-1:0]       i_occupancy,
    input  logic                   i_evicted,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
        logic              sgn;
        logic [OCC_W-1:0]  occ;
        logic              evicted;
    } t_resp;

    logic                slot_used   [CAPACITY];
    logic [KEY_BITS-1:0] slot_key    [CAPACITY];
    logic [VST_W-1:0]    slot_val    [CAPACITY];
    logic [DATA_W-1:0]   slot_expiry [CAPACITY];
    logic                slot_sgn    [CAPACITY];
    int unsigned         slot_rank   [CAPACITY];
    int unsigned         held;
    logic [CFG_W-1:0]    limit_reg;
    t_resp               resp_q[$];
    t_resp               want;

    // Make slot s most recent; entries more recent than it move down one rank.
    function automatic void promote(input int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && i != s && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void drop_slot(input int s);
        int unsigned r;
        r = slot_rank[s];
        slot_used[s] = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && slot_rank[i] > r)
                slot_rank[i]--;
        if (held > 0)
            held--;
    endfunction

    function automatic t_resp cache_access(
        input logic                   op,
        input logic [KEY_FIELD_W-1:0] key_in,
        input logic [DATA_W-1:0]      wval,
        input logic [DATA_W-1:0]      ttl,
        input logic                   wsig,
        input logic [DATA_W-1:0]      now
    );
        t_resp               r;
        logic [KEY_BITS-1:0] k;
        logic [DATA_W:0]     sum;
        logic [DATA_W-1:0]   expiry_at;
        int                  lim;
        int                  s;
        int                  v;
        r = '0;
        k = key_in[KEY_BITS-1:0];
        // lowest slot holding the key
        s = -1;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (slot_used[i] && slot_key[i] == k)
                s = i;
        if (op == OP_LOOKUP) begin
            if (s >= 0) begin
                if (now > slot_expiry[s]) begin
                    drop_slot(s);
                end else begin
                    promote(s);
                    r.hit   = 1'b1;
                    r.value = slot_val[s];
                    r.sgn   = slot_sgn[s];
                end
            end
        end else begin
            sum       = {1'b0, now} + {1'b0, ttl};
            expiry_at = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
            lim       = int'(limit_reg);
            if (lim < 1)
                lim = 1;
            if (lim > CAPACITY)
                lim = CAPACITY;
            if (s < 0) begin
                if (held >= lim) begin
                    v = -1;
                    for (int i = 0; i < CAPACITY; i++)
                        if (slot_used[i] && (v < 0 || slot_rank[i] > slot_rank[v]))
                            v = i;
                    if (v >= 0) begin
                        drop_slot(v);
                        r.evicted = 1'b1;
                    end
                end
                // take the lowest free slot
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (!slot_used[i])
                        s = i;
                if (s >= 0) begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (slot_used[i])
                            slot_rank[i]++;
                    slot_used[s] = 1'b1;
                    slot_key[s]  = k;
                    slot_rank[s] = 0;
                    held++;
                end
            end else begin
                promote(s);
            end
            if (s >= 0) begin
                slot_val[s]    = wval[VST_W-1:0];
                slot_expiry[s] = expiry_at;
                slot_sgn[s]    = wsig;
            end
        end
        r.occ = OCC_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
            held         = 0;
            limit_reg    = MAX_ENTRIES_RST;
            o_fail_count = 0;
            resp_q.delete();
        end else begin
            if (i_cfg_we)
                limit_reg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (resp_q.size() == 0) begin
                    $display("%0t: response with none outstanding: hit %0d value %h occ %0d",
                             $time, i_hit, i_read_value, i_occupancy);
                    o_fail_count++;
                end else begin
                    want = resp_q.pop_front();
                    if (i_hit !== want.hit) begin
                        $display("%0t: hit mismatch: expected %0d, actual %0d",
                                 $time, want.hit, i_hit);
                        o_fail_count++;
                    end
                    if (i_read_value !== want.value) begin
                        $display("%0t: read_value mismatch: expected %h, actual %h",
                                 $time, want.value, i_read_value);
                        o_fail_count++;
                    end
                    if (i_read_signed_ok !== want.sgn) begin
                        $display("%0t: read_signed_ok mismatch: expected %0d, actual %0d",
                                 $time, want.sgn, i_read_signed_ok);
                        o_fail_count++;
                    end
                    if (i_occupancy !== want.occ) begin
                        $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                                 $time, want.occ, i_occupancy);
                        o_fail_count++;
                    end
                    if (i_evicted !== want.evicted) begin
                        $display("%0t: evicted mismatch: expected %0d, actual %0d",
                                 $time, want.evicted, i_evicted);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                resp_q.push_back(cache_access(i_opcode, i_lookup_key, i_write_value,
                                              i_time_to_live, i_write_signed_ok,
                                              i_now_seconds));
        end
        o_pending = resp_q.size();
    end

endmodule

// ----- tb/lru_cache_with_expiry_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_unit_tb
// Drives the LRU cache with directed corner requests and then random phases at
// several entry limits, with random idling on both channels and one long
// response hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module lru_cache_with_expiry_unit_tb;
    import lruc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // settle time after draining, longer than the walk of one request
    localparam int SETTLE      = CAPACITY + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 180;
    localparam int NUM_PHASES  = 10;
    localparam int POOL_SIZE   = 128;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic                   req_opcode;
    logic [KEY_FIELD_W-1:0] req_key;
    logic [DATA_W-1:0]      req_value;
    logic [DATA_W-1:0]      req_ttl;
    logic                   req_signed_ok;
    logic [DATA_W-1:0]      req_now;
    logic                   out_valid;
    logic                   out_stall;
    logic                   rsp_hit;
    logic [DATA_W-1:0]      rsp_value;
    logic                   rsp_signed_ok;
    logic [OCC_W-1:0]       rsp_occupancy;
    logic                   rsp_evicted;
    int                     fail_count;
    int                     pending;

    // quiet: no idling on either side; hold_start: ask the receiver for a long stall
    logic                   quiet;
    logic                   hold_start;
    logic [KEY_FIELD_W-1:0] key_pool [POOL_SIZE];
    logic [DATA_W-1:0]      clock_now;

    lru_cache_with_expiry_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (req_opcode),
        .i_lookup_key      (req_key),
        .i_write_value     (req_value),
        .i_time_to_live    (req_ttl),
        .i_write_signed_ok (req_signed_ok),
        .i_now_seconds     (req_now),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_hit             (rsp_hit),
        .o_read_value      (rsp_value),
        .o_read_signed_ok  (rsp_signed_ok),
        .o_occupancy       (rsp_occupancy),
        .o_evicted         (rsp_evicted)
    );

    lru_cache_with_expiry_unit_checker u_resp_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_opcode          (req_opcode),
        .i_lookup_key      (req_key),
        .i_write_value     (req_value),
        .i_time_to_live    (req_ttl),
        .i_write_signed_ok (req_signed_ok),
        .i_now_seconds     (req_now),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_hit             (rsp_hit),
        .i_read_value      (rsp_value),
        .i_read_signed_ok  (rsp_signed_ok),
        .i_occupancy       (rsp_occupancy),
        .i_evicted         (rsp_evicted),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: give up well past the slowest correct run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall at random, except in the quiet stretch, and hold off for
    // a long stretch once asked so the block backs up into its request side.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_start) begin
                hold_start = 1'b0;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 21);
        end
    end

    // Offer one request; idle at random first, then hold it until taken.
    // Enter and leave at a falling edge.
    task automatic issue(
        input logic                   op,
        input logic [KEY_FIELD_W-1:0] key,
        input logic [DATA_W-1:0]      wval,
        input logic [DATA_W-1:0]      ttl,
        input logic                   wsig,
        input logic [DATA_W-1:0]      now
    );
        if (!quiet)
            while ($urandom_range(0, 99) < 21) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid      <= 1'b1;
        req_opcode    <= op;
        req_key       <= key;
        req_value     <= wval;
        req_ttl       <= ttl;
        req_signed_ok <= wsig;
        req_now       <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid, wait for every outstanding response, then let the walk settle.
    task automatic drain_responses();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write the entry limit only while the block is idle.
    task automatic set_limit(input logic [CFG_W-1:0] v);
        drain_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0]       phase_limit [NUM_PHASES];
        logic [KEY_FIELD_W-1:0] key;
        logic [DATA_W-1:0]      ttl;
        logic                   op;
        int                     eff;
        int                     span;
        int                     pick;

        // Drive every input to a known value before the first edge.
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        req_opcode    = OP_LOOKUP;
        req_key       = '0;
        req_value     = '0;
        req_ttl       = '0;
        req_signed_ok = 1'b0;
        req_now       = '0;
        quiet         = 1'b0;
        hold_start    = 1'b0;
        clock_now     = '0;

        // After the reset limit, the extremes: lowest limit, zero (acts as one), above capacity.
        phase_limit = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd64, 7'd5, 7'd100, 7'd3, 7'd40};

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // ---------------- directed part, reset limit of 64 ----------------
        // lookup into an empty cache
        issue(OP_LOOKUP, '0, '0, '0, 1'b0, '0);
        // all-ones write: expiry saturates at the top of the time range
        issue(OP_WRITE, '1, '1, '1, 1'b1, '1);
        // expiry equal to now still hits
        issue(OP_LOOKUP, '1, '0, '0, 1'b0, '1);
        issue(OP_WRITE, '0, '0, '0, 1'b0, 32'd100);
        issue(OP_LOOKUP, '0, '0, '0, 1'b0, 32'd100);
        // one second later the entry expires and is removed
        issue(OP_LOOKUP, '0, '0, '0, 1'b0, 32'd101);
        issue(OP_LOOKUP, '0, '0, '0, 1'b0, 32'd101);
        // update of a held key ignores its old, expired lifetime
        issue(OP_WRITE, 64'd5, 32'h1234_5678, 32'd10, 1'b1, 32'd0);
        issue(OP_WRITE, 64'd5, 32'hCAFE_0001, 32'd0, 1'b0, 32'd1000);
        issue(OP_LOOKUP, 64'd5, '0, '0, 1'b0, 32'd1000);
        // sum lands exactly on the maximum, then one that overflows
        issue(OP_WRITE, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
              32'h8000_0000);
        issue(OP_WRITE, 64'd6, 32'h0000_0001, 32'h8000_0000, 1'b1, 32'h8000_0000);
        issue(OP_LOOKUP, 64'd6, '0, '0, 1'b0, '1);

        // Lower the limit below occupancy: each new key evicts exactly one.
        set_limit(7'd2);
        issue(OP_WRITE, 64'd7, 32'h0000_0007, 32'd50, 1'b0, 32'd2000);
        issue(OP_LOOKUP, 64'd6, '0, '0, 1'b0, 32'd2000);
        issue(OP_WRITE, 64'd8, 32'h0000_0008, 32'd50, 1'b1, 32'd2000);
        issue(OP_WRITE, 64'd9, 32'h0000_0009, 32'd50, 1'b0, 32'd2001);
        issue(OP_LOOKUP, 64'd7, '0, '0, 1'b0, 32'd2001);
        issue(OP_LOOKUP, 64'd6, '0, '0, 1'b0, 32'd2001);
        // zero limit acts as one entry
        set_limit(7'd0);
        issue(OP_WRITE, 64'd10, 32'h0000_000A, 32'd50, 1'b1, 32'd2002);
        issue(OP_WRITE, 64'd11, 32'h0000_000B, 32'd50, 1'b0, 32'd2002);
        issue(OP_LOOKUP, 64'd11, '0, '0, 1'b0, 32'd2002);

        // ---------------- random phases ----------------
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_limit(phase_limit[ph]);
            eff  = (phase_limit[ph] == 0) ? 1 :
                   (phase_limit[ph] > CAPACITY) ? CAPACITY : int'(phase_limit[ph]);
            // a key pool a little wider than the limit keeps hits and evictions coming
            span = eff + eff / 2 + 3;
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            // one phase without any idling on either side
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 40)
                    hold_start = 1'b1;
                op = ($urandom_range(0, 99) < 60) ? OP_WRITE : OP_LOOKUP;
                if ($urandom_range(0, 9) == 0)
                    key = {$urandom, $urandom};
                else
                    key = key_pool[$urandom_range(0, span - 1)];
                // advance time slowly so entries age out; jump now and then
                if ($urandom_range(0, 99) < 3)
                    clock_now = $urandom;
                else
                    clock_now = clock_now + $urandom_range(0, 3);
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    ttl = $urandom_range(0, 60);
                else if (pick < 85)
                    ttl = $urandom;
                else if (pick < 95)
                    ttl = 32'hFFFF_FFFF - $urandom_range(0, 255);
                else
                    ttl = '0;
                issue(op, key, $urandom, ttl, 1'($urandom_range(0, 1)), clock_now);
            end
        end
        quiet = 1'b0;

        drain_responses();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lruc_pkg.sv
rtl/core/lruc_ram.sv
rtl/core/lruc_scan.sv
rtl/core/lru_cache_with_expiry_unit.sv
tb/lru_cache_with_expiry_unit_checker.sv
tb/lru_cache_with_expiry_unit_tb.sv
